// ----- sv/aps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package aps_pkg;
	localparam int MAX_COLS_DEF  = 1024;
	localparam int FRAC_BITS_DEF = 24;
	localparam int NUM_REGS      = 8;
	localparam int REG_W         = 31;
	localparam int IDX_W         = 3;
	localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
	localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

	typedef enum logic [IDX_W-1:0] {
		REG_ALPHA = 3'd0,
		REG_DT    = 3'd1,
		REG_KK    = 3'd2,
		REG_TA    = 3'd3,
		REG_RB    = 3'd4,
		REG_EPS   = 3'd5,
		REG_M1    = 3'd6,
		REG_M2    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] top;
		logic signed [31:0] bot;
		logic signed [31:0] west;
		logic signed [31:0] east;
		logic signed [31:0] ctr;
		logic signed [31:0] rec;
		logic               last;
	} stencil_t;

	typedef struct packed {
		logic [REG_W-1:0] alpha;
		logic [REG_W-1:0] dt;
		logic [REG_W-1:0] kk;
		logic [REG_W-1:0] ta;
		logic [REG_W-1:0] rb;
		logic [REG_W-1:0] eps;
		logic [REG_W-1:0] m1;
		logic [REG_W-1:0] m2;
	} coef_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'(Q_MAX)) return 32'sh7fffffff;
		if (v < 66'(Q_MIN)) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage
`default_nettype wire

// ----- sv/aps_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface aps_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] excite_prev;
	logic signed [31:0] recovery_in;
	logic               row_end;
	logic               frame_end;
	modport source(output valid, excite_prev, recovery_in, row_end, frame_end, input ready);
	modport sink(input valid, excite_prev, recovery_in, row_end, frame_end, output ready);
endinterface

interface aps_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] excite_next;
	logic signed [31:0] recovery_next;
	logic               frame_last;
	modport source(output valid, excite_next, recovery_next, frame_last, input ready);
	modport sink(input valid, excite_next, recovery_next, frame_last, output ready);
endinterface
`default_nettype wire

// ----- sv/aps_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module aps_front #(
	parameter int MAX_COLS = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic signed [31:0] ein,
	input  wire logic signed [31:0] rin,
	input  wire logic              row_end,
	input  wire logic              frame_end,
	output logic                   st_valid,
	input  wire logic              st_ready,
	output aps_pkg::stencil_t      st
);
	import aps_pkg::*;
	localparam int SLOTS = MAX_COLS + 2;
	localparam int AW    = $clog2(SLOTS);
	localparam int CW    = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {
		S_TAKE = 3'b001,
		S_READ = 3'b010,
		S_PUSH = 3'b100
	} fstate_t;

	fstate_t state_q;
	logic signed [31:0] row0_mem [SLOTS];
	logic signed [31:0] row1_mem [SLOTS];
	logic signed [31:0] row2_mem [SLOTS];
	logic signed [31:0] rec0_mem [SLOTS];
	logic signed [31:0] rec1_mem [SLOTS];
	logic [CW-1:0] col_q;
	logic [1:0]    seen_q;
	logic [1:0]    ecur_q;
	logic          rcur_q;
	logic signed [31:0] ein_q;
	logic          fe_q, re_q, gen_q;
	logic signed [31:0] a0_q, a1_q, a2_q, rc0_q, rc1_q;
	logic signed [31:0] top_w_q, mid1_q, mid2_q, bot_w_q, rec_w_q;
	stencil_t st_q;
	logic signed [31:0] mid_c, top_c, rr;

	assign in_ready = (state_q == S_TAKE);
	assign st_valid = (state_q == S_PUSH);
	assign st = st_q;

	always_ff @(posedge clk) begin
		if (in_ready && in_valid && col_q < CW'(SLOTS)) begin
			case (ecur_q)
				2'd0: row0_mem[col_q[AW-1:0]] <= ein;
				2'd1: row1_mem[col_q[AW-1:0]] <= ein;
				default: row2_mem[col_q[AW-1:0]] <= ein;
			endcase
			if (rcur_q) rec1_mem[col_q[AW-1:0]] <= rin;
			else rec0_mem[col_q[AW-1:0]] <= rin;
		end
	end

	// one read per bank at the current column, the window keeps earlier columns
	always_ff @(posedge clk) begin
		a0_q  <= row0_mem[col_q[AW-1:0]];
		a1_q  <= row1_mem[col_q[AW-1:0]];
		a2_q  <= row2_mem[col_q[AW-1:0]];
		rc0_q <= rec0_mem[col_q[AW-1:0]];
		rc1_q <= rec1_mem[col_q[AW-1:0]];
	end

	always_comb begin
		case (ecur_q)
			2'd0: begin
				top_c = a1_q; mid_c = a2_q;
			end
			2'd1: begin
				top_c = a2_q; mid_c = a0_q;
			end
			default: begin
				top_c = a0_q; mid_c = a1_q;
			end
		endcase
		rr = rcur_q ? rc0_q : rc1_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_TAKE;
			col_q   <= '0;
			seen_q  <= '0;
			ecur_q  <= '0;
			rcur_q  <= 1'b0;
		end else begin
			case (state_q)
				S_TAKE: begin
					if (in_valid) begin
						gen_q <= (col_q < CW'(SLOTS)) && seen_q == 2'd2 && col_q >= CW'(2);
						ein_q <= ein;
						fe_q  <= frame_end;
						re_q  <= row_end;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					st_q.top  <= top_w_q;
					st_q.bot  <= bot_w_q;
					st_q.west <= mid2_q;
					st_q.east <= mid_c;
					st_q.ctr  <= mid1_q;
					st_q.rec  <= rec_w_q;
					st_q.last <= fe_q;
					top_w_q <= top_c;
					mid2_q  <= mid1_q;
					mid1_q  <= mid_c;
					bot_w_q <= ein_q;
					rec_w_q <= rr;
					if (fe_q) begin
						col_q  <= '0;
						seen_q <= '0;
						ecur_q <= (ecur_q == 2'd2) ? 2'd0 : ecur_q + 2'd1;
						rcur_q <= ~rcur_q;
					end else if (re_q) begin
						col_q  <= '0;
						if (seen_q != 2'd2) seen_q <= seen_q + 2'd1;
						ecur_q <= (ecur_q == 2'd2) ? 2'd0 : ecur_q + 2'd1;
						rcur_q <= ~rcur_q;
					end else if (col_q < CW'(SLOTS)) begin
						col_q <= col_q + CW'(1);
					end
					state_q <= gen_q ? S_PUSH : S_TAKE;
				end
				S_PUSH: begin
					if (st_ready) state_q <= S_TAKE;
				end
				default: state_q <= S_TAKE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- sv/aps_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module aps_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_valid,
	output logic              wr_ready,
	input  wire aps_pkg::stencil_t wr_data,
	output logic              rd_valid,
	input  wire logic         rd_ready,
	output aps_pkg::stencil_t rd_data
);
	import aps_pkg::*;
	stencil_t slot_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) slot_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr_valid && wr_ready) wp_q <= ~wp_q;
			if (rd_valid && rd_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'((wr_valid && wr_ready) ? 1 : 0)
				- 2'((rd_valid && rd_ready) ? 1 : 0);
		end
	end
endmodule
`default_nettype wire

// ----- sv/aps_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module aps_div #(
	parameter int FRAC_BITS = 24
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [31:0] num,
	input  wire logic signed [31:0] den,
	output logic                    done,
	output logic signed [31:0]      quo
);
	import aps_pkg::*;
	localparam int NW = 32 + FRAC_BITS;
	localparam int SW = $clog2(NW + 1);
	logic [NW-1:0] n_q, q_q;
	logic [32:0]   d_q, rem_q;
	logic          neg_q, busy_q, zero_q;
	logic signed [31:0] zq_q;
	logic [SW-1:0] k_q;
	logic [33:0]   trial;
	logic signed [65:0] sres;

	assign trial = {rem_q, n_q[NW-1]} - {1'b0, d_q};
	assign sres = neg_q ? -$signed(66'(q_q)) : $signed(66'(q_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				n_q    <= NW'(num[31] ? 33'(-$signed({num[31], num})) : 33'(num)) << FRAC_BITS;
				d_q    <= den[31] ? 33'(-$signed({den[31], den})) : 33'(den);
				neg_q  <= num[31] ^ den[31];
				zero_q <= (den == 0);
				zq_q   <= (num == 0) ? 32'sd0 : (num[31] ? 32'sh80000000 : 32'sh7fffffff);
				rem_q  <= '0;
				q_q    <= '0;
				k_q    <= SW'(NW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (zero_q || k_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
					quo    <= zero_q ? zq_q : sat32(sres);
				end else begin
					if (!trial[33]) rem_q <= trial[32:0];
					else rem_q <= {rem_q[31:0], n_q[NW-1]};
					q_q   <= {q_q[NW-2:0], ~trial[33]};
					n_q   <= n_q << 1;
					k_q   <= k_q - SW'(1);
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- sv/aps_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module aps_back #(
	parameter int FRAC_BITS = 24
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               st_valid,
	output logic                    st_ready,
	input  wire aps_pkg::stencil_t  st,
	input  wire aps_pkg::coef_t     coef,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      excite_next,
	output logic signed [31:0]      recovery_next,
	output logic                    frame_last
);
	import aps_pkg::*;
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_CALC = 4'b0010,
		B_DIV  = 4'b0100,
		B_OUT  = 4'b1000
	} bstate_t;

	bstate_t state_q;
	logic [4:0] step_q;
	logic signed [31:0] c_q, r_q, e1_q, t1_q, t2_q, t3_q, e2_q, quo_q, gn_q;
	logic last_q;
	logic signed [31:0] ma, mb, mres;
	logic signed [63:0] prod;
	logic signed [31:0] lap;
	logic div_start, div_done;
	logic signed [31:0] div_q;

	function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return sat32(66'(a) + 66'(b));
	endfunction
	function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return sat32(66'(a) - 66'(b));
	endfunction
	function automatic logic signed [31:0] uq(input logic [REG_W-1:0] v);
		return $signed({1'b0, v});
	endfunction

	assign lap = sat32(66'(st.top) + 66'(st.bot) + 66'(st.west) + 66'(st.east)
		- (66'(st.ctr) <<< 2));
	assign prod = 64'(ma) * 64'(mb);
	assign mres = sat32(66'(prod >>> FRAC_BITS));

	// one shared multiplier, operands chosen per step
	always_comb begin
		ma = '0; mb = '0;
		case (step_q)
			5'd0: begin ma = uq(coef.alpha); mb = t1_q; end
			5'd1: begin ma = uq(coef.kk); mb = e1_q; end
			5'd2: begin ma = t1_q; mb = qsub(e1_q, uq(coef.ta)); end
			5'd3: begin ma = t1_q; mb = qsub(e1_q, ONE); end
			5'd4: begin ma = e1_q; mb = r_q; end
			5'd5: begin ma = uq(coef.dt); mb = qadd(t1_q, t2_q); end
			5'd6: begin ma = uq(coef.m1); mb = r_q; end
			5'd7: begin ma = uq(coef.kk); mb = e2_q; end
			5'd8: begin ma = t3_q; mb = qsub(qsub(e2_q, uq(coef.rb)), ONE); end
			5'd9: begin ma = uq(coef.dt); mb = qadd(uq(coef.eps), quo_q); end
			5'd10: begin ma = gn_q; mb = qsub(sat32(-66'(r_q)), t3_q); end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	assign div_start = (state_q == B_CALC) && step_q == 5'd6;

	aps_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(mres), .den(qadd(e2_q, uq(coef.m2))),
		.done(div_done), .quo(div_q)
	);

	assign st_ready  = (state_q == B_IDLE);
	assign out_valid = (state_q == B_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				B_IDLE: if (st_valid) begin
					c_q <= st.ctr; r_q <= st.rec; last_q <= st.last;
					t1_q <= lap; step_q <= '0; state_q <= B_CALC;
				end
				B_CALC: begin
					step_q <= step_q + 5'd1;
					case (step_q)
						5'd0: e1_q <= qadd(c_q, mres);
						5'd1, 5'd2, 5'd3: t1_q <= mres;
						5'd4: t2_q <= mres;
						5'd5: e2_q <= qsub(e1_q, mres);
						5'd6: state_q <= B_DIV;
						5'd7: t3_q <= mres;
						5'd8: t3_q <= mres;
						5'd9: gn_q <= mres;
						5'd10: begin
							recovery_next <= qadd(r_q, mres);
							excite_next   <= e2_q;
							frame_last    <= last_q;
							state_q       <= B_OUT;
						end
						default: state_q <= B_IDLE;
					endcase
				end
				B_DIV: if (div_done) begin
					quo_q <= div_q; state_q <= B_CALC;
				end
				B_OUT: if (out_ready) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- sv/aliev_panfilov_stencil_step_core.sv -----
// a beat passes through the front, the queue and the back end in that order; the back end
// finishes sooner when the recovery divisor is zero
// pacing: the front takes a beat and reads its window, and pushes a stencil when it hands one on,
// taking no new beat before it is through; cells with a result are bounded by the back end,
// set by the bit-serial quotient unit and the shared multiplier
// reset clears counters, handshakes and coefficients to defaults; line buffers are not cleared
`timescale 1ns / 1ps
`default_nettype none
module aliev_panfilov_stencil_step_core #(
	parameter int MAX_COLS  = aps_pkg::MAX_COLS_DEF,
	parameter int FRAC_BITS = aps_pkg::FRAC_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	aps_in_if.sink                       in_ch,
	aps_out_if.source                    out_ch,
	input  wire logic                    cfg_we,
	input  wire logic [aps_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [aps_pkg::REG_W-1:0] cfg_data
);
	import aps_pkg::*;
	coef_t coef_q;
	stencil_t f_st, q_st;
	logic f_valid, f_ready, q_valid, q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.alpha <= '0;
			coef_q.dt    <= '0;
			coef_q.kk    <= 31'd134217728;
			coef_q.ta    <= 31'd1677722;
			coef_q.rb    <= 31'd1677722;
			coef_q.eps   <= 31'd167772;
			coef_q.m1    <= 31'd1174405;
			coef_q.m2    <= 31'd5033165;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ALPHA: coef_q.alpha <= cfg_data;
				REG_DT:    coef_q.dt    <= cfg_data;
				REG_KK:    coef_q.kk    <= cfg_data;
				REG_TA:    coef_q.ta    <= cfg_data;
				REG_RB:    coef_q.rb    <= cfg_data;
				REG_EPS:   coef_q.eps   <= cfg_data;
				REG_M1:    coef_q.m1    <= cfg_data;
				REG_M2:    coef_q.m2    <= cfg_data;
				default: ;
			endcase
		end
	end

	aps_front #(.MAX_COLS(MAX_COLS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.ein(in_ch.excite_prev), .rin(in_ch.recovery_in),
		.row_end(in_ch.row_end), .frame_end(in_ch.frame_end),
		.st_valid(f_valid), .st_ready(f_ready), .st(f_st)
	);

	aps_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_st),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_st)
	);

	aps_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.st_valid(q_valid), .st_ready(q_ready), .st(q_st), .coef(coef_q),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.excite_next(out_ch.excite_next), .recovery_next(out_ch.recovery_next),
		.frame_last(out_ch.frame_last)
	);

`ifndef NO_ASSERTIONS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.excite_next))
		else $error("result dropped under stall");
	a_q_guard: assert property (@(posedge clk) disable iff (!arst_n)
		f_valid && !f_ready |=> f_valid && $stable(f_st))
		else $error("stencil dropped under stall");
	a_back_take: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && q_ready |=> !out_ch.valid)
		else $error("result raised on take");
`endif
endmodule
`default_nettype wire
